>>> hw/rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants, types and the arctangent table of the great-circle
// distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int GCD_ITERATIONS = 24;

  localparam logic [15:0]        RADIUS_RESET = 16'd6371;
  localparam logic signed [23:0] LAT_LIMIT    = 24'sd5898240;
  localparam logic signed [24:0] LON_LIMIT    = 25'sd11796480;
  localparam logic [32:0]        RAD_PER_UNIT = 33'd4797524517;
  localparam logic [30:0]        Q30_ONE      = 31'd1073741824;
  localparam logic [30:0]        Q30_HALF_PI  = 31'd1686629713;
  localparam logic [31:0]        Q30_PI       = 32'd3373259426;
  localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
  localparam logic [25:0]        DIST_MAX     = 26'h3FFFFFF;

  // four angles: half lat diff, half lon diff, lat1, lat2
  typedef logic [3:0][30:0] ang4_t;
  // two Q30 values: sin and cos of the half central angle
  typedef logic [1:0][30:0] pair_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    unique case (idx % 32)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/gcd_front.sv
// ----------------------------------------------------------------------------
// gcd_front
// Clamp coordinates, form differences and convert to Q30 radians (3 stages).
// ----------------------------------------------------------------------------
module gcd_front import gcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [23:0] lat1,
  input  logic signed [24:0] lon1,
  input  logic signed [23:0] lat2,
  input  logic signed [24:0] lon2,
  output logic               out_vld,
  output ang4_t              ang
);

  logic [2:0]             vld_r;
  logic [3:0][24:0]       mag_r;
  logic [3:0][57:0]       prod_r;
  ang4_t                  ang_r;

  logic signed [23:0] lat1_c, lat2_c;
  logic signed [24:0] lon1_c, lon2_c;
  logic signed [25:0] dlat, dlon;
  logic [3:0][24:0]   mag_nxt;
  logic [3:0][58:0]   rnd;
  logic [3:0][31:0]   h;
  logic signed [33:0] fold;
  ang4_t              ang_nxt;

  always_comb begin
    lat1_c = (lat1 > LAT_LIMIT) ? LAT_LIMIT : ((lat1 < -LAT_LIMIT) ? -LAT_LIMIT : lat1);
    lat2_c = (lat2 > LAT_LIMIT) ? LAT_LIMIT : ((lat2 < -LAT_LIMIT) ? -LAT_LIMIT : lat2);
    lon1_c = (lon1 > LON_LIMIT) ? LON_LIMIT : ((lon1 < -LON_LIMIT) ? -LON_LIMIT : lon1);
    lon2_c = (lon2 > LON_LIMIT) ? LON_LIMIT : ((lon2 < -LON_LIMIT) ? -LON_LIMIT : lon2);
    dlat = 26'(lat2_c) - 26'(lat1_c);
    dlon = 26'(lon2_c) - 26'(lon1_c);
    mag_nxt[0] = 25'(dlat[25] ? -dlat : dlat);
    mag_nxt[1] = 25'(dlon[25] ? -dlon : dlon);
    mag_nxt[2] = 25'(lat1_c[23] ? -26'(lat1_c) : 26'(lat1_c));
    mag_nxt[3] = 25'(lat2_c[23] ? -26'(lat2_c) : 26'(lat2_c));
  end

  // round half up on the magnitude: half angles shift by 25, full by 24
  always_comb begin
    rnd[0] = 59'(prod_r[0]) + (59'd1 << 24);
    rnd[1] = 59'(prod_r[1]) + (59'd1 << 24);
    rnd[2] = 59'(prod_r[2]) + (59'd1 << 23);
    rnd[3] = 59'(prod_r[3]) + (59'd1 << 23);
    h[0] = rnd[0][56:25];
    h[1] = rnd[1][56:25];
    h[2] = rnd[2][55:24];
    h[3] = rnd[3][55:24];
    fold = 34'(Q30_PI) - 34'(h[1]);
    ang_nxt[0] = (h[0] > 32'(Q30_HALF_PI)) ? Q30_HALF_PI : h[0][30:0];
    ang_nxt[2] = (h[2] > 32'(Q30_HALF_PI)) ? Q30_HALF_PI : h[2][30:0];
    ang_nxt[3] = (h[3] > 32'(Q30_HALF_PI)) ? Q30_HALF_PI : h[3][30:0];
    // past a quarter turn, fold back: sin^2 is unchanged
    if (h[1] <= 32'(Q30_HALF_PI)) begin
      ang_nxt[1] = h[1][30:0];
    end else if (fold < 0) begin
      ang_nxt[1] = '0;
    end else if (fold > 34'(Q30_HALF_PI)) begin
      ang_nxt[1] = Q30_HALF_PI;
    end else begin
      ang_nxt[1] = fold[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      for (int l = 0; l < 4; l++) begin
        prod_r[l] <= 58'(mag_r[l]) * 58'(RAD_PER_UNIT);
      end
      ang_r <= ang_nxt;
    end
  end

  assign out_vld = vld_r[2];
  assign ang     = ang_r;

endmodule

>>> hw/rtl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos
// Four-lane rotation CORDIC, one micro-rotation per stage. Lanes 0 and 1
// return the sine, lanes 2 and 3 the cosine, clamped to 0..1.
// ----------------------------------------------------------------------------
module gcd_sincos import gcd_pkg::*; #(
  parameter int ITER = GCD_ITERATIONS
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  ang4_t ang,
  output logic  out_vld,
  output ang4_t res
);

  logic [ITER:0]      vld_r;
  logic signed [32:0] x_r [0:ITER][0:3];
  logic signed [32:0] y_r [0:ITER][0:3];
  logic signed [31:0] z_r [0:ITER][0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ITER-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        x_r[0][l] <= CORDIC_GAIN;
        y_r[0][l] <= '0;
        z_r[0][l] <= signed'(32'(ang[l]));
      end
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          if (z_r[i][l] >= 0) begin
            x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] - signed'(atan_q30(i));
          end else begin
            x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] + signed'(atan_q30(i));
          end
        end
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_out
    logic signed [32:0] v;
    assign v = (l < 2) ? y_r[ITER][l] : x_r[ITER][l];
    assign res[l] = (v < 0) ? '0 : ((v > 33'(Q30_ONE)) ? Q30_ONE : v[30:0]);
  end

  assign out_vld = vld_r[ITER];

endmodule

>>> hw/rtl/gcd_hav.sv
// ----------------------------------------------------------------------------
// gcd_hav
// Haversine term a = s1^2 + s2^2*c1*c2 in Q30, clamped to 0..1 (4 stages).
// ----------------------------------------------------------------------------
module gcd_hav import gcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  ang4_t       sc,
  output logic        out_vld,
  output logic [30:0] a
);

  logic [3:0]  vld_r;
  logic [30:0] a1_r [0:2];
  logic [30:0] t1_r, t2_r, t3_r, a_r;
  logic [30:0] c1_r, c2_r [0:1];
  logic [61:0] p_a, p_t1, p_t2, p_t3;
  logic [31:0] sum;

  always_comb begin
    p_a  = 62'(sc[0]) * 62'(sc[0]);
    p_t1 = 62'(sc[1]) * 62'(sc[1]);
    p_t2 = 62'(t1_r) * 62'(c1_r);
    p_t3 = 62'(t2_r) * 62'(c2_r[1]);
    sum  = 32'(a1_r[2]) + 32'(t3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r[0] <= p_a[60:30];
      t1_r    <= p_t1[60:30];
      c1_r    <= sc[2];
      c2_r[0] <= sc[3];
      a1_r[1] <= a1_r[0];
      t2_r    <= p_t2[60:30];
      c2_r[1] <= c2_r[0];
      a1_r[2] <= a1_r[1];
      t3_r    <= p_t3[60:30];
      a_r     <= (sum > 32'(Q30_ONE)) ? Q30_ONE : sum[30:0];
    end
  end

  assign out_vld = vld_r[3];
  assign a       = a_r;

endmodule

>>> hw/rtl/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// gcd_isqrt
// Two-lane bitwise integer square root, one result bit per stage:
// lane 0 gives sqrt(a << 30), lane 1 gives sqrt((1 - a) << 30).
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [30:0] a,
  output logic        out_vld,
  output pair_t       root
);

  localparam int STEPS = 31;

  logic [STEPS:0] vld_r;
  logic [61:0]    v_r [0:STEPS][0:1];
  logic [61:0]    q_r [0:STEPS][0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0][0] <= {1'b0, a, 30'd0};
      v_r[0][1] <= {1'b0, 31'(Q30_ONE - a), 30'd0};
      q_r[0][0] <= '0;
      q_r[0][1] <= '0;
    end
  end

  // operand stays below 2^62, so the top trial bit never fits: start at 2^60
  for (genvar j = 0; j < STEPS; j++) begin : g_bit
    localparam logic [61:0] B = 62'd1 << (60 - 2 * j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (v_r[j][l] >= q_r[j][l] + B) begin
            v_r[j+1][l] <= v_r[j][l] - (q_r[j][l] + B);
            q_r[j+1][l] <= (q_r[j][l] >> 1) + B;
          end else begin
            v_r[j+1][l] <= v_r[j][l];
            q_r[j+1][l] <= q_r[j][l] >> 1;
          end
        end
      end
    end
  end

  assign root[0] = q_r[STEPS][0][30:0];
  assign root[1] = q_r[STEPS][1][30:0];
  assign out_vld = vld_r[STEPS];

endmodule

>>> hw/rtl/gcd_atan.sv
// ----------------------------------------------------------------------------
// gcd_atan
// Vectoring CORDIC for atan2(y, x) with x, y >= 0, one micro-rotation per
// stage; result in Q30 clamped to 0..pi/2, exactly zero when y is zero.
// ----------------------------------------------------------------------------
module gcd_atan import gcd_pkg::*; #(
  parameter int ITER = GCD_ITERATIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  pair_t       yx,
  output logic        out_vld,
  output logic [30:0] ang
);

  logic [ITER:0]      vld_r;
  logic [ITER:0]      zero_r;
  logic signed [32:0] x_r [0:ITER];
  logic signed [32:0] y_r [0:ITER];
  logic signed [31:0] z_r [0:ITER];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ITER-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= {zero_r[ITER-1:0], (yx[0] == '0)};
      y_r[0] <= signed'(33'(yx[0]));
      x_r[0] <= signed'(33'(yx[1]));
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + signed'(atan_q30(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - signed'(atan_q30(i));
        end
      end
    end
  end

  always_comb begin
    if (zero_r[ITER] || z_r[ITER] < 0) begin
      ang = '0;
    end else if (z_r[ITER] > signed'(32'(Q30_HALF_PI))) begin
      ang = Q30_HALF_PI;
    end else begin
      ang = z_r[ITER][30:0];
    end
  end

  assign out_vld = vld_r[ITER];

endmodule

>>> hw/rtl/great_circle_distance_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Haversine great-circle distance between two latitude/longitude points.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per point pair (lat1, lon1, lat2, lon2 in 1/65536 deg).
//   out_* : one word per pair, distance in km with 8 fraction bits.
//   cfg_* : sphere radius in whole km, written while the block is idle;
//           cfg_ready is always high.
// Throughput: one word per cycle unless stalled. Every pair passes through
//   the same fully pipelined datapath: front conversion (3), sin/cos
//   CORDIC (ITER+1), haversine products (4), square roots (32), arctangent
//   CORDIC (ITER+1) and radius scaling (2).
// Reset: empties the pipeline and loads a radius of 6371 km.
// Stall: while out_tvalid is high and out_tready low, the whole pipeline
//   holds and in_tready drops; bubbles never overwrite held words.
// ----------------------------------------------------------------------------
module great_circle_distance_top import gcd_pkg::*; #(
  parameter int APPROX_ITERATIONS = GCD_ITERATIONS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
  // second_longitude[97:73], zero pad[103:98]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance[25:0], zero pad[31:26]
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  logic        en;
  logic [15:0] radius_r;
  logic        fr_vld, sc_vld, hv_vld, sq_vld, at_vld;
  ang4_t       fr_ang, sc_res;
  logic [30:0] hv_a, at_ang;
  pair_t       sq_root;
  logic        prod_vld_r, out_vld_r;
  logic [47:0] prod_r;
  logic [25:0] dist_r;
  logic [26:0] quo;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  gcd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_tvalid),
    .lat1   (signed'(in_tdata[23:0])),
    .lon1   (signed'(in_tdata[48:24])),
    .lat2   (signed'(in_tdata[72:49])),
    .lon2   (signed'(in_tdata[97:73])),
    .out_vld(fr_vld),
    .ang    (fr_ang)
  );

  gcd_sincos #(.ITER(APPROX_ITERATIONS)) u_sincos (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (fr_vld),
    .ang    (fr_ang),
    .out_vld(sc_vld),
    .res    (sc_res)
  );

  gcd_hav u_hav (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (sc_vld),
    .sc     (sc_res),
    .out_vld(hv_vld),
    .a      (hv_a)
  );

  gcd_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (hv_vld),
    .a      (hv_a),
    .out_vld(sq_vld),
    .root   (sq_root)
  );

  gcd_atan #(.ITER(APPROX_ITERATIONS)) u_atan (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (sq_vld),
    .yx     (sq_root),
    .out_vld(at_vld),
    .ang    (at_ang)
  );

  // central angle is twice the half angle: scale, round and drop 21 bits
  assign quo = prod_r[47:21];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (en) begin
      prod_vld_r <= at_vld;
      out_vld_r  <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 48'(radius_r) * 48'(at_ang) + (48'd1 << 20);
      dist_r <= (quo > 27'(DIST_MAX)) ? DIST_MAX : quo[25:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, dist_r};

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the output word is held");

  a_angle_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(at_ang) && $stable(at_vld))
    else $error("pipeline moved during a stall");

  a_hav_range: assert property (@(posedge clk) disable iff (!rst_n)
    hv_vld |-> hv_a <= Q30_ONE)
    else $error("haversine term above one");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    at_vld |-> at_ang <= Q30_HALF_PI)
    else $error("half central angle above a quarter turn");
`endif

endmodule

>>> dv/great_circle_distance_top_tb.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top_tb
// Drives coordinate pairs into the haversine pipeline under several sphere
// radii. A directed table comes first, then random pairs. Both sides idle
// at random. Each distance word is compared with a software model of the
// fixed-point datapath.
// ----------------------------------------------------------------------------
module great_circle_distance_top_tb;
  import gcd_pkg::*;

  localparam int  N_ITER      = 24;
  localparam int  PIPE_DELAY  = 2 * N_ITER + 43;
  localparam int  N_RANDOM    = 530;
  localparam longint ONE_Q30  = 64'd1073741824;
  localparam longint HPI_Q30  = 64'd1686629713;
  localparam longint PI_Q30   = 64'd3373259426;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam longint unsigned RAD_SCALE = 64'd4797524517;
  localparam longint LAT_MAX  = 64'd5898240;
  localparam longint LON_MAX  = 64'd11796480;

  localparam longint ATAN_TAB [24] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};

  typedef struct packed {
    logic signed [24:0] lon2;
    logic signed [23:0] lat2;
    logic signed [24:0] lon1;
    logic signed [23:0] lat1;
  } pair_word_t;

  typedef struct {
    pair_word_t pts;
    bit         known;
    logic [25:0] km;
  } route_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  logic [15:0]  radius_km = RADIUS_RESET;
  logic [25:0]  dist_q[$];
  int           n_fail = 0;
  bit           in_done = 1'b0;
  int           stall_left = 0;

  great_circle_distance_top u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // degree units to Q30 radians, rounding half up on the magnitude
  function automatic longint deg_to_rad(longint u, int sh);
    longint unsigned mag, r;
    mag = u < 0 ? -u : u;
    r = (mag * RAD_SCALE + (64'd1 << (sh - 1))) >> sh;
    return u < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic void rotate_sincos(longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = GAIN_Q30; y = 0; z = ang;
    for (int i = 0; i < N_ITER; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    s = clampl(y, 0, ONE_Q30);
    c = clampl(x, 0, ONE_Q30);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_atan(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < N_ITER; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return clampl(z, 0, HPI_Q30);
  endfunction

  function automatic logic [25:0] haversine_km(pair_word_t p);
    longint la1, lo1, la2, lo2, hlat, hlon, r1, r2, s1, s2, c1, c2, tmp;
    longint unsigned a, t, root, rest, ang, km_q8;
    la1 = clampl(longint'(p.lat1), -LAT_MAX, LAT_MAX);
    lo1 = clampl(longint'(p.lon1), -LON_MAX, LON_MAX);
    la2 = clampl(longint'(p.lat2), -LAT_MAX, LAT_MAX);
    lo2 = clampl(longint'(p.lon2), -LON_MAX, LON_MAX);
    hlat = deg_to_rad(la2 - la1, 25);
    hlon = deg_to_rad(lo2 - lo1, 25);
    r1 = deg_to_rad(la1, 24);
    r2 = deg_to_rad(la2, 24);
    if (hlat < 0) hlat = -hlat;
    if (hlon < 0) hlon = -hlon;
    if (r1 < 0) r1 = -r1;
    if (r2 < 0) r2 = -r2;
    hlat = clampl(hlat, 0, HPI_Q30);
    // fold the half longitude difference back below a quarter turn
    if (hlon > HPI_Q30) hlon = clampl(PI_Q30 - hlon, 0, HPI_Q30);
    r1 = clampl(r1, 0, HPI_Q30);
    r2 = clampl(r2, 0, HPI_Q30);
    rotate_sincos(hlat, s1, tmp);
    rotate_sincos(hlon, s2, tmp);
    rotate_sincos(r1, tmp, c1);
    rotate_sincos(r2, tmp, c2);
    a = (longint'(s1) * longint'(s1)) >> 30;
    t = (longint'(s2) * longint'(s2)) >> 30;
    t = (t * c1) >> 30;
    t = (t * c2) >> 30;
    a += t;
    if (a > ONE_Q30) a = ONE_Q30;
    root = int_sqrt(a << 30);
    rest = int_sqrt((ONE_Q30 - a) << 30);
    ang = vector_atan(root, rest);
    km_q8 = (64'(radius_km) * ang + (64'd1 << 20)) >> 21;
    if (km_q8 > 64'(DIST_MAX)) km_q8 = 64'(DIST_MAX);
    return km_q8[25:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one word, log its expected distance on the accepting edge
  task automatic send_pair(pair_word_t p, bit known, logic [25:0] exp_dist,
                           bit calm);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (known && exp_dist != haversine_km(p)) begin
      $error("table row distance: expected %0d model %0d", exp_dist, haversine_km(p));
      n_fail++;
    end
    dist_q = {dist_q, (known ? exp_dist : haversine_km(p))};
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_radius(logic [15:0] v);
    in_tvalid <= 1'b0;
    wait (dist_q.size() == 0);
    repeat (PIPE_DELAY + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    radius_km = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] any_lat(int mode);
    if (mode == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 2 * 5898240)) - 5898240);
  endfunction

  function automatic logic signed [24:0] any_lon(int mode);
    if (mode == 0) return 25'($urandom);
    return 25'($signed($urandom_range(0, 2 * 11796480)) - 11796480);
  endfunction

  function automatic pair_word_t random_pair();
    pair_word_t p;
    int r;
    r = $urandom_range(0, 99);
    p.lat1 = any_lat(r < 15 ? 0 : 1);
    p.lon1 = any_lon(r < 15 ? 0 : 1);
    p.lat2 = any_lat(r < 15 ? 0 : 1);
    p.lon2 = any_lon(r < 15 ? 0 : 1);
    if (r >= 80 && r < 90) begin
      // nearby points: tiny haversine term
      p.lat2 = p.lat1 + 24'($signed($urandom_range(0, 64)) - 32);
      p.lon2 = p.lon1 + 25'($signed($urandom_range(0, 64)) - 32);
    end else if (r >= 90) begin
      // near antipodal: term close to one
      p.lat2 = -p.lat1 + 24'($signed($urandom_range(0, 1024)) - 512);
      p.lon2 = (p.lon1 >= 0) ? p.lon1 - 25'sd11796480 : p.lon1 + 25'sd11796480;
    end
    return p;
  endfunction

  route_row_t route_tab[$];

  function automatic route_row_t row(int la1, int lo1, int la2, int lo2,
                                     bit known, logic [25:0] d);
    route_row_t x;
    x.pts.lat1 = 24'(la1); x.pts.lon1 = 25'(lo1);
    x.pts.lat2 = 24'(la2); x.pts.lon2 = 25'(lo2);
    x.known = known; x.km = d;
    return x;
  endfunction

  // check every distance word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (dist_q.size() == 0) begin
        $error("distance word with nothing expected: %0d", out_tdata[25:0]);
        n_fail++;
      end else begin
        logic [25:0] want;
        want = dist_q.pop_front();
        if (out_tdata[25:0] !== want) begin
          $error("distance: expected %0d actual %0d", want, out_tdata[25:0]);
          n_fail++;
        end
      end
    end
  end

  // receiver stalls: calm stretches alternate with random back-pressure
  always @(posedge clk) begin
    int g;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!in_done && ($urandom_range(0, 99) < 40)) begin
      out_tready <= 1'b1;
    end else begin
      g = pick_gap();
      out_tready <= (g == 0);
      if (g > 1) stall_left <= g - 1;
    end
  end

  initial begin
    route_tab = '{
      row(0, 0, 0, 0, 1, 26'd0),
      row(5898240, 11796480, 5898240, 11796480, 1, 26'd0),
      row(-5898240, -11796480, -5898240, -11796480, 1, 26'd0),
      row(8388607, 16777215, 5898240, 11796480, 1, 26'd0),
      row(-8388608, -16777216, -5898240, -11796480, 1, 26'd0),
      row(5898240, 0, -5898240, 0, 0, 0),
      row(0, -11796480, 0, 11796480, 0, 0),
      row(0, 0, 0, 11796480, 0, 0),
      row(0, -11796480, 0, 5898240, 0, 0),
      row(0, -8000000, 0, 8000000, 0, 0),
      row(8388607, 0, -8388608, 0, 0, 0),
      row(0, 16777215, 0, -16777216, 0, 0),
      row(0, 0, 1, 1, 0, 0),
      row(0, 0, 0, 1, 0, 0),
      row(2949120, 1000, -2949120, -11795000, 0, 0),
      row(-1, -1, 1, 1, 0, 0),
      row(3000000, 5000000, -4000000, -7000000, 0, 0),
      row(5898240, -11796480, -5898240, 11796480, 0, 0)
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (route_tab[i])
      send_pair(route_tab[i].pts, route_tab[i].known, route_tab[i].km, i < 6);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_radius(16'd1);
        1: write_radius(16'hFFFF);
        2: write_radius(16'd0);
        3: write_radius(16'($urandom_range(1, 65535)));
        4: write_radius(16'($urandom_range(1, 65535)));
        default: write_radius(RADIUS_RESET);
      endcase
      send_pair('{lon2: 25'sd11796480, lat2: 24'sd0, lon1: 25'sd0, lat1: 24'sd0},
                0, 0, 1'b0);
      for (int k = 0; k < N_RANDOM / 6; k++)
        send_pair(random_pair(), 0, 0, (k / 30) % 3 == 0);
    end
    in_tvalid <= 1'b0;
    in_done = 1'b1;
    wait (dist_q.size() == 0);
    repeat (PIPE_DELAY + 20) @(posedge clk);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
